[hw/rtl/jsbd_pkg.sv]
// Shared types and constants for the JSON string body decoder.
`timescale 1ns / 1ps

package jsbd_pkg;

   // Decoder phase: plain text, after backslash, first \u digits,
   // backslash and u of a surrogate pair, second \u digits
   typedef enum logic [3:0] {
      PH_PLAIN = 4'd0,
      PH_ESC   = 4'd1,
      PH_HEX1  = 4'd2,
      PH_HEX2  = 4'd3,
      PH_HEX3  = 4'd4,
      PH_HEX4  = 4'd5,
      PH_BSL   = 4'd6,
      PH_U     = 4'd7,
      PH_LOW1  = 4'd8,
      PH_LOW2  = 4'd9,
      PH_LOW3  = 4'd10,
      PH_LOW4  = 4'd11
   } phase_type;

   // Result status codes
   typedef enum logic [3:0] {
      ST_RUN     = 4'd0,
      ST_DONE    = 4'd1,
      ST_CTRL    = 4'd2,
      ST_BADESC  = 4'd3,
      ST_BADHEX  = 4'd4,
      ST_NOU     = 4'd5,
      ST_NOTLOW  = 4'd6,
      ST_LONELOW = 4'd7,
      ST_EOF     = 4'd8
   } status_type;

   localparam int CP_W    = 21;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;
   localparam int QCNT_W  = 2;

   localparam logic [CP_W-1:0] CTRL_MAX  = 21'h1F;
   localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

   // Character codes of interest
   localparam logic [CP_W-1:0] CH_QUOTE = 21'h22;
   localparam logic [CP_W-1:0] CH_BSL   = 21'h5C;
   localparam logic [CP_W-1:0] CH_SLASH = 21'h2F;
   localparam logic [CP_W-1:0] CH_B     = 21'h62;
   localparam logic [CP_W-1:0] CH_F     = 21'h66;
   localparam logic [CP_W-1:0] CH_N     = 21'h6E;
   localparam logic [CP_W-1:0] CH_R     = 21'h72;
   localparam logic [CP_W-1:0] CH_T     = 21'h74;
   localparam logic [CP_W-1:0] CH_U     = 21'h75;

   // Classified character handed from front to back
   typedef struct packed {
      status_type            status;
      logic                  encode;
      logic [CP_W-1:0]       cp;
   } cmd_type;

   // Front-to-queue push
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

endpackage

[hw/rtl/jsbd_front.sv]
// Front end: accepts characters, runs the escape phase machine, emits commands.
`timescale 1ns / 1ps

module jsbd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [jsbd_pkg::CP_W-1:0] cp,
   input  logic                     eoi,
   input  logic                     q_full,
   output jsbd_pkg::push_type       push
);

   jsbd_pkg::phase_type phase_ff, phase_in;
   logic [15:0]         acc_ff, acc_in;
   logic [9:0]          high_ff, high_in;

   logic                accept;
   logic                dig_ok;
   logic [3:0]          dig;
   logic [15:0]         acc_next;
   jsbd_pkg::cmd_type   cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Hex digit decode
   always_comb begin
      dig_ok = 1'b0;
      dig    = cp[3:0];
      if (cp inside {[21'h30:21'h39]}) begin
         dig_ok = 1'b1;
      end else if (cp inside {[21'h41:21'h46], [21'h61:21'h66]}) begin
         dig_ok = 1'b1;
         dig    = cp[3:0] + 4'd9;
      end
   end

   assign acc_next = {acc_ff[11:0], dig};

   // Next phase and command for the current character
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      high_in    = high_ff;
      cmd.status = jsbd_pkg::ST_RUN;
      cmd.encode = 1'b0;
      cmd.cp     = cp;
      if (eoi) begin
         cmd.status = jsbd_pkg::ST_EOF;
      end else begin
         case (phase_ff)
            jsbd_pkg::PH_ESC: begin
               if (cp <= jsbd_pkg::CTRL_MAX) begin
                  cmd.status = jsbd_pkg::ST_CTRL;
               end else begin
                  phase_in = jsbd_pkg::PH_PLAIN;
                  case (cp)
                     jsbd_pkg::CH_QUOTE, jsbd_pkg::CH_BSL, jsbd_pkg::CH_SLASH: begin
                        cmd.encode = 1'b1;
                     end
                     jsbd_pkg::CH_B: begin
                        cmd.encode = 1'b1;
                        cmd.cp     = 21'h08;
                     end
                     jsbd_pkg::CH_F: begin
                        cmd.encode = 1'b1;
                        cmd.cp     = 21'h0C;
                     end
                     jsbd_pkg::CH_N: begin
                        cmd.encode = 1'b1;
                        cmd.cp     = 21'h0A;
                     end
                     jsbd_pkg::CH_R: begin
                        cmd.encode = 1'b1;
                        cmd.cp     = 21'h0D;
                     end
                     jsbd_pkg::CH_T: begin
                        cmd.encode = 1'b1;
                        cmd.cp     = 21'h09;
                     end
                     jsbd_pkg::CH_U: begin
                        acc_in   = 16'd0;
                        phase_in = jsbd_pkg::PH_HEX1;
                     end
                     default: begin
                        cmd.status = jsbd_pkg::ST_BADESC;
                     end
                  endcase
               end
            end
            jsbd_pkg::PH_HEX1, jsbd_pkg::PH_HEX2, jsbd_pkg::PH_HEX3,
            jsbd_pkg::PH_LOW1, jsbd_pkg::PH_LOW2, jsbd_pkg::PH_LOW3: begin
               if (!dig_ok) begin
                  cmd.status = jsbd_pkg::ST_BADHEX;
               end else begin
                  acc_in   = acc_next;
                  phase_in = jsbd_pkg::phase_type'(phase_ff + 4'd1);
               end
            end
            jsbd_pkg::PH_HEX4: begin
               if (!dig_ok) begin
                  cmd.status = jsbd_pkg::ST_BADHEX;
               end else begin
                  acc_in = 16'd0;
                  if (acc_next[15:10] == 6'b110110) begin
                     high_in  = acc_next[9:0];
                     phase_in = jsbd_pkg::PH_BSL;
                  end else if (acc_next[15:10] == 6'b110111) begin
                     cmd.status = jsbd_pkg::ST_LONELOW;
                  end else begin
                     cmd.encode = 1'b1;
                     cmd.cp     = {5'd0, acc_next};
                     phase_in   = jsbd_pkg::PH_PLAIN;
                  end
               end
            end
            jsbd_pkg::PH_LOW4: begin
               if (!dig_ok) begin
                  cmd.status = jsbd_pkg::ST_BADHEX;
               end else begin
                  acc_in = 16'd0;
                  if (acc_next[15:10] != 6'b110111) begin
                     cmd.status = jsbd_pkg::ST_NOTLOW;
                  end else begin
                     // join the surrogate pair
                     cmd.encode = 1'b1;
                     cmd.cp     = jsbd_pkg::SUPP_BASE + {1'b0, high_ff, acc_next[9:0]};
                     high_in    = 10'd0;
                     phase_in   = jsbd_pkg::PH_PLAIN;
                  end
               end
            end
            jsbd_pkg::PH_BSL: begin
               if (cp != jsbd_pkg::CH_BSL) cmd.status = jsbd_pkg::ST_NOU;
               else                        phase_in   = jsbd_pkg::PH_U;
            end
            jsbd_pkg::PH_U: begin
               if (cp != jsbd_pkg::CH_U) begin
                  cmd.status = jsbd_pkg::ST_NOU;
               end else begin
                  acc_in   = 16'd0;
                  phase_in = jsbd_pkg::PH_LOW1;
               end
            end
            default: begin
               // plain text; unused phase codes behave the same
               phase_in = jsbd_pkg::PH_PLAIN;
               if (cp <= jsbd_pkg::CTRL_MAX)   cmd.status = jsbd_pkg::ST_CTRL;
               else if (cp == jsbd_pkg::CH_BSL)  phase_in   = jsbd_pkg::PH_ESC;
               else if (cp == jsbd_pkg::CH_QUOTE) cmd.status = jsbd_pkg::ST_DONE;
               else                              cmd.encode = 1'b1;
            end
         endcase
      end
      // end of string or error: back to a clean start
      if (cmd.status != jsbd_pkg::ST_RUN) begin
         phase_in   = jsbd_pkg::PH_PLAIN;
         acc_in     = 16'd0;
         high_in    = 10'd0;
         cmd.encode = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= jsbd_pkg::PH_PLAIN;
         acc_ff   <= 16'd0;
         high_ff  <= 10'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         high_ff  <= high_in;
      end
   end

   assign push.valid = accept;
   assign push.cmd   = cmd;

endmodule

[hw/rtl/jsbd_queue.sv]
// Two-entry command queue between the front end and the encoder.
`timescale 1ns / 1ps

module jsbd_queue (
   input  logic               clock,
   input  logic               reset,
   input  jsbd_pkg::push_type push,
   output logic               full,
   output logic               head_valid,
   output jsbd_pkg::cmd_type  head,
   input  logic               pop
);

   jsbd_pkg::cmd_type                 mem_ff [jsbd_pkg::QDEPTH];
   logic [jsbd_pkg::QPTR_W-1:0]       wr_ff, wr_in;
   logic [jsbd_pkg::QPTR_W-1:0]       rd_ff, rd_in;
   logic [jsbd_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                              do_pop;

   assign full       = (cnt_ff == jsbd_pkg::QCNT_W'(jsbd_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_in  = push.valid ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push.valid && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (!push.valid && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.cmd;
      end
   end

endmodule

[hw/rtl/jsbd_back.sv]
// Back end: UTF-8 encoder with the result output register.
`timescale 1ns / 1ps

module jsbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  jsbd_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata
);

   logic        valid_ff, valid_in;
   logic [39:0] data_ff, data_in;
   logic [2:0]  count;
   logic [7:0]  b0, b1, b2, b3;
   logic [20:0] c;

   assign c   = head.cp;
   assign pop = head_valid && (!valid_ff || rsp_tready);

   // UTF-8 byte layout by code point range
   always_comb begin
      count = 3'd0;
      b0    = 8'd0;
      b1    = 8'd0;
      b2    = 8'd0;
      b3    = 8'd0;
      if (head.encode && head.status == jsbd_pkg::ST_RUN) begin
         if (c < 21'h80) begin
            count = 3'd1;
            b0    = c[7:0];
         end else if (c < 21'h800) begin
            count = 3'd2;
            b0    = {3'b110, c[10:6]};
            b1    = {2'b10, c[5:0]};
         end else if (c < 21'h10000) begin
            count = 3'd3;
            b0    = {4'b1110, c[15:12]};
            b1    = {2'b10, c[11:6]};
            b2    = {2'b10, c[5:0]};
         end else begin
            count = 3'd4;
            b0    = {5'b11110, c[20:18]};
            b1    = {2'b10, c[17:12]};
            b2    = {2'b10, c[11:6]};
            b3    = {2'b10, c[5:0]};
         end
      end
   end

   // Output register: load on pop, drop on take
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = {1'b0, head.status, b3, b2, b1, b0, count};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

[hw/rtl/json_string_body_decoder_core.sv]
// Top level of the JSON string body decoder.
// Each result is written into a queue entry, then loaded into the output register.
// One character per cycle if the queue has room; one escape phase step per character.
// Under output stall the two-entry queue plus the output register hold three results.
// Reset (synchronous, active high) returns to the plain phase with an empty queue and no result.
// Exactly one result transaction is produced per accepted input transaction.
`timescale 1ns / 1ps

module json_string_body_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [20:0] code_point, [23:21] zero
   input  logic        req_tlast,   // end_of_input
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [2:0] byte_count, [10:3] out_byte0,
                                    // [18:11] out_byte1, [26:19] out_byte2,
                                    // [34:27] out_byte3, [38:35] status, [39] zero
);

   jsbd_pkg::push_type push;
   jsbd_pkg::cmd_type  head;
   logic               q_full;
   logic               head_valid;
   logic               pop;

   jsbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cp         (req_tdata[20:0]),
      .eoi        (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   jsbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   jsbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[hw/rtl/jsbd_checker.sv]
// Port-level checks for the JSON string body decoder, bound to the top level.
`timescale 1ns / 1ps

module jsbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_rst_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // finished or failed strings carry no bytes
   a_status_nobytes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[38:35] != jsbd_pkg::ST_RUN |-> rsp_tdata[2:0] == 3'd0)
      else $error("bytes with terminal status");

   // byte count is at most four
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= 3'd4)
      else $error("byte count out of range");

   // byte three is zero unless the count is four
   a_tail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] != 3'd4 |-> rsp_tdata[34:27] == 8'd0)
      else $error("unused byte not zero");

endmodule

bind json_string_body_decoder_core jsbd_checker u_jsbd_checker (.*);

[verif/json_string_body_decoder_core_tb.sv]
// Self-checking testbench for the JSON string body decoder core.
`timescale 1ns / 1ps

module json_string_body_decoder_core_tb;

   localparam int RANDOM_CHARS = 1650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int N_DIRECTED   = 26;

   // One decoded result, laid out as rsp_tdata[38:0] (first member is the top)
   typedef struct packed {
      jsbd_pkg::status_type status;
      logic [7:0]           out_byte3;
      logic [7:0]           out_byte2;
      logic [7:0]           out_byte1;
      logic [7:0]           out_byte0;
      logic [2:0]           byte_count;
   } utf8_result_type;

   // Directed row: character, end flag, and a hand-written result where typed is set
   typedef struct {
      logic [20:0]     cp;
      logic            eoi;
      bit              typed;
      utf8_result_type want;
   } char_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // Decoder state as the testbench sees it
   jsbd_pkg::phase_type dec_phase = jsbd_pkg::PH_PLAIN;
   logic [15:0]         dec_hex   = '0;
   logic [9:0]          dec_high  = '0;

   utf8_result_type pending_utf8[$];

   int  fail_count  = 0;
   int  chars_sent  = 0;
   int  results_seen = 0;
   int  done_n = 0, error_n = 0, eof_n = 0, four_byte_n = 0;
   int  cycle_count = 0;
   bit  rsp_took = 1'b0;
   bit  tx_fast  = 1'b0;

   // status, byte3, byte2, byte1, byte0, count
   char_row_type directed_rows [N_DIRECTED] = '{
      '{21'h41, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h41, 3'd1}},
      '{21'h00, 1'b0, 1'b1,
        '{jsbd_pkg::ST_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CTRL_MAX, 1'b0, 1'b1,
        '{jsbd_pkg::ST_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{21'h20, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h20, 3'd1}},
      // above the Unicode range: still encoded as four bytes
      '{21'h1FFFFF, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'hBF, 8'hBF, 8'hBF, 8'hF7, 3'd4}},
      '{21'h10FFFF, 1'b0, 1'b0, '0},
      // bare surrogate in plain text: three bytes, no error
      '{21'h00D800, 1'b0, 1'b0, '0},
      '{21'h80,     1'b0, 1'b0, '0},
      '{21'h1FFFFF, 1'b1, 1'b1,
        '{jsbd_pkg::ST_EOF, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_BSL, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_N, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h0A, 3'd1}},
      '{jsbd_pkg::CH_BSL, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{21'h01, 1'b0, 1'b1,
        '{jsbd_pkg::ST_CTRL, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_BSL, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{21'h78, 1'b0, 1'b1,
        '{jsbd_pkg::ST_BADESC, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      // high surrogate \uD83d, then a character where a backslash belongs
      '{jsbd_pkg::CH_BSL, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_U, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{21'h44,     1'b0, 1'b0, '0},
      '{21'h38,     1'b0, 1'b0, '0},
      '{21'h33,     1'b0, 1'b0, '0},
      '{21'h64,     1'b0, 1'b0, '0},
      '{21'h41, 1'b0, 1'b1,
        '{jsbd_pkg::ST_NOU, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      // non-hex digit inside \u
      '{jsbd_pkg::CH_BSL, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_U, 1'b0, 1'b1,
        '{jsbd_pkg::ST_RUN, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{21'h5A, 1'b0, 1'b1,
        '{jsbd_pkg::ST_BADHEX, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}},
      '{jsbd_pkg::CH_QUOTE, 1'b0, 1'b1,
        '{jsbd_pkg::ST_DONE, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0}}
   };

   json_string_body_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------

   function automatic int hex_nibble(logic [20:0] c);
      if (c >= 21'h30 && c <= 21'h39) return int'(c - 21'h30);
      if (c >= 21'h41 && c <= 21'h46) return int'(c - 21'h41) + 10;
      if (c >= 21'h61 && c <= 21'h66) return int'(c - 21'h61) + 10;
      return -1;
   endfunction

   function automatic utf8_result_type utf8_of(logic [20:0] cp);
      utf8_result_type r;
      r = '0;
      if (cp < 21'h80) begin
         r.byte_count = 3'd1;
         r.out_byte0  = cp[7:0];
      end else if (cp < 21'h800) begin
         r.byte_count = 3'd2;
         r.out_byte0  = {3'b110, cp[10:6]};
         r.out_byte1  = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.byte_count = 3'd3;
         r.out_byte0  = {4'b1110, cp[15:12]};
         r.out_byte1  = {2'b10, cp[11:6]};
         r.out_byte2  = {2'b10, cp[5:0]};
      end else begin
         r.byte_count = 3'd4;
         r.out_byte0  = {5'b11110, cp[20:18]};
         r.out_byte1  = {2'b10, cp[17:12]};
         r.out_byte2  = {2'b10, cp[11:6]};
         r.out_byte3  = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   // Advance the decoder state by one character and return its result
   function automatic utf8_result_type decode_char(logic [20:0] cp, logic eoi);
      utf8_result_type r;
      logic [15:0]     acc;
      int              nib;
      r   = '0;
      nib = hex_nibble(cp);
      acc = {dec_hex[11:0], 4'(nib)};
      if (eoi) begin
         r.status = jsbd_pkg::ST_EOF;
      end else begin
         case (dec_phase)
            jsbd_pkg::PH_ESC: begin
               if (cp <= jsbd_pkg::CTRL_MAX) begin
                  r.status = jsbd_pkg::ST_CTRL;
               end else begin
                  dec_phase = jsbd_pkg::PH_PLAIN;
                  case (cp)
                     jsbd_pkg::CH_QUOTE, jsbd_pkg::CH_BSL, jsbd_pkg::CH_SLASH: r = utf8_of(cp);
                     jsbd_pkg::CH_B: r = utf8_of(21'h08);
                     jsbd_pkg::CH_F: r = utf8_of(21'h0C);
                     jsbd_pkg::CH_N: r = utf8_of(21'h0A);
                     jsbd_pkg::CH_R: r = utf8_of(21'h0D);
                     jsbd_pkg::CH_T: r = utf8_of(21'h09);
                     jsbd_pkg::CH_U: begin
                        dec_hex   = '0;
                        dec_phase = jsbd_pkg::PH_HEX1;
                     end
                     default: r.status = jsbd_pkg::ST_BADESC;
                  endcase
               end
            end
            jsbd_pkg::PH_HEX1, jsbd_pkg::PH_HEX2, jsbd_pkg::PH_HEX3, jsbd_pkg::PH_HEX4,
            jsbd_pkg::PH_LOW1, jsbd_pkg::PH_LOW2, jsbd_pkg::PH_LOW3, jsbd_pkg::PH_LOW4: begin
               if (nib < 0) begin
                  r.status = jsbd_pkg::ST_BADHEX;
               end else if (dec_phase == jsbd_pkg::PH_HEX4) begin
                  dec_hex = '0;
                  if (acc >= 16'hD800 && acc <= 16'hDBFF) begin
                     dec_high  = acc[9:0];
                     dec_phase = jsbd_pkg::PH_BSL;
                  end else if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
                     r.status = jsbd_pkg::ST_LONELOW;
                  end else begin
                     r         = utf8_of({5'd0, acc});
                     dec_phase = jsbd_pkg::PH_PLAIN;
                  end
               end else if (dec_phase == jsbd_pkg::PH_LOW4) begin
                  dec_hex = '0;
                  if (acc < 16'hDC00 || acc > 16'hDFFF) begin
                     r.status = jsbd_pkg::ST_NOTLOW;
                  end else begin
                     r         = utf8_of(jsbd_pkg::SUPP_BASE + {1'b0, dec_high, acc[9:0]});
                     dec_high  = '0;
                     dec_phase = jsbd_pkg::PH_PLAIN;
                  end
               end else begin
                  dec_hex   = acc;
                  dec_phase = jsbd_pkg::phase_type'(dec_phase + 4'd1);
               end
            end
            jsbd_pkg::PH_BSL: begin
               if (cp != jsbd_pkg::CH_BSL) r.status = jsbd_pkg::ST_NOU;
               else dec_phase = jsbd_pkg::PH_U;
            end
            jsbd_pkg::PH_U: begin
               if (cp != jsbd_pkg::CH_U) begin
                  r.status = jsbd_pkg::ST_NOU;
               end else begin
                  dec_hex   = '0;
                  dec_phase = jsbd_pkg::PH_LOW1;
               end
            end
            default: begin
               // plain text, and any unused phase value
               dec_phase = jsbd_pkg::PH_PLAIN;
               if (cp <= jsbd_pkg::CTRL_MAX) r.status = jsbd_pkg::ST_CTRL;
               else if (cp == jsbd_pkg::CH_BSL) dec_phase = jsbd_pkg::PH_ESC;
               else if (cp == jsbd_pkg::CH_QUOTE) r.status = jsbd_pkg::ST_DONE;
               else r = utf8_of(cp);
            end
         endcase
      end
      // closing quote or error: no bytes, back to a clean start
      if (r.status != jsbd_pkg::ST_RUN) begin
         r           = '{r.status, 8'h00, 8'h00, 8'h00, 8'h00, 3'd0};
         dec_phase   = jsbd_pkg::PH_PLAIN;
         dec_hex     = '0;
         dec_high    = '0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Character source
   // ---------------------------------------------------------------

   task automatic send_char(input logic [20:0] cp, input logic eoi, input bit typed,
                            input utf8_result_type want);
      int              gap;
      utf8_result_type predicted;
      gap = tx_fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, cp};
      req_tlast  <= eoi;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = decode_char(cp, eoi);
      pending_utf8.push_back(typed ? want : predicted);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_cp(input logic [20:0] cp);
      send_char(cp, 1'b0, 1'b0, '0);
   endtask

   function automatic logic [20:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 21'h30 + n;
      return ($urandom_range(0, 1) ? 21'h41 : 21'h61) + (n - 4'd10);
   endfunction

   task automatic send_hex4(input logic [15:0] v);
      send_cp(hex_char(v[15:12]));
      send_cp(hex_char(v[11:8]));
      send_cp(hex_char(v[7:4]));
      send_cp(hex_char(v[3:0]));
   endtask

   // A text character that neither ends the string nor starts an escape
   function automatic logic [20:0] plain_cp();
      logic [20:0] c;
      case ($urandom_range(0, 7))
         0, 1, 2: begin
            c = 21'($urandom_range(21'h20, 21'h7E));
            if (c == jsbd_pkg::CH_QUOTE || c == jsbd_pkg::CH_BSL)
               c = 21'h41 + 21'($urandom_range(0, 25));
         end
         3: c = 21'($urandom_range(21'h80, 21'h7FF));
         4: c = 21'($urandom_range(21'h800, 21'hFFFF));
         5: c = 21'($urandom_range(21'h10000, 21'h10FFFF));
         6: c = 21'($urandom_range(21'h110000, 21'h1FFFFF));
         default: c = 21'($urandom_range(21'hD800, 21'hDFFF));
      endcase
      return c;
   endfunction

   // Anything at all, weighted toward control characters and hex digits
   function automatic logic [20:0] wild_cp();
      case ($urandom_range(0, 3))
         0: return 21'($urandom_range(0, 31));
         1: return 21'($urandom_range(0, 21'h1FFFFF));
         2: return hex_char(4'($urandom_range(0, 15)));
         default: return plain_cp();
      endcase
   endfunction

   function automatic logic [20:0] esc_letter();
      case ($urandom_range(0, 7))
         0: return jsbd_pkg::CH_QUOTE;
         1: return jsbd_pkg::CH_BSL;
         2: return jsbd_pkg::CH_SLASH;
         3: return jsbd_pkg::CH_B;
         4: return jsbd_pkg::CH_F;
         5: return jsbd_pkg::CH_N;
         6: return jsbd_pkg::CH_R;
         default: return jsbd_pkg::CH_T;
      endcase
   endfunction

   task automatic send_u_escape(input logic [15:0] v);
      send_cp(jsbd_pkg::CH_BSL);
      send_cp(jsbd_pkg::CH_U);
      send_hex4(v);
   endtask

   // One piece of a string body: mostly well formed, sometimes broken
   task automatic send_piece();
      int          k;
      int          n;
      logic [15:0] v;
      k = $urandom_range(0, 99);
      if (k < 45) begin
         send_cp(plain_cp());
      end else if (k < 60) begin
         send_cp(jsbd_pkg::CH_BSL);
         send_cp(esc_letter());
      end else if (k < 70) begin
         v = 16'($urandom_range(0, 16'hFFFF));
         if (v[15:11] == 5'b11011) v[15] = 1'b0;
         send_u_escape(v);
      end else if (k < 80) begin
         send_u_escape({6'b110110, 10'($urandom_range(0, 1023))});
         send_u_escape({6'b110111, 10'($urandom_range(0, 1023))});
      end else begin
         case ($urandom_range(0, 7))
            0: send_cp(21'($urandom_range(0, 31)));
            1: begin
               send_cp(jsbd_pkg::CH_BSL);
               send_cp(wild_cp());
            end
            2: begin
               send_cp(jsbd_pkg::CH_BSL);
               send_cp(jsbd_pkg::CH_U);
               n = $urandom_range(0, 3);
               repeat (n) send_cp(hex_char(4'($urandom_range(0, 15))));
               send_cp(wild_cp());
            end
            3: begin
               send_u_escape({6'b110110, 10'($urandom_range(0, 1023))});
               send_cp(wild_cp());
            end
            4: begin
               send_u_escape({6'b110110, 10'($urandom_range(0, 1023))});
               send_cp(jsbd_pkg::CH_BSL);
               send_cp(wild_cp());
            end
            5: begin
               send_u_escape({6'b110110, 10'($urandom_range(0, 1023))});
               send_u_escape(16'($urandom_range(0, 16'hFFFF)));
            end
            6: send_u_escape({6'b110111, 10'($urandom_range(0, 1023))});
            default: send_char(21'($urandom_range(0, 21'h1FFFFF)), 1'b1, 1'b0, '0);
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // Result sink: ready pattern and checking
   // ---------------------------------------------------------------

   initial begin : sink_side
      int stall_left;
      int hold_left;
      bit held;
      bit fast;
      stall_left = 0;
      hold_left  = 0;
      held       = 1'b0;
      fast       = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         // one long back-pressure stretch so the input side stalls
         if (!held && results_seen >= 300) begin
            held      = 1'b1;
            hold_left = 150;
         end
         if (rsp_took) begin
            if ($urandom_range(0, 63) == 0) fast = !fast;
            stall_left = fast ? 0 : $urandom_range(0, 16);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic check_result(input logic [39:0] data);
      utf8_result_type got;
      utf8_result_type want;
      got = utf8_result_type'(data[38:0]);
      results_seen++;
      case (got.status)
         jsbd_pkg::ST_RUN: ;
         jsbd_pkg::ST_DONE: done_n++;
         jsbd_pkg::ST_EOF: eof_n++;
         default: error_n++;
      endcase
      if (got.byte_count == 3'd4) four_byte_n++;
      if (pending_utf8.size() == 0) begin
         $error("unexpected result transaction, tdata %h", data);
         fail_count++;
      end else begin
         want = pending_utf8.pop_front();
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
            fail_count++;
         end
         if (got.out_byte0 !== want.out_byte0) begin
            $error("out_byte0: expected %h, got %h", want.out_byte0, got.out_byte0);
            fail_count++;
         end
         if (got.out_byte1 !== want.out_byte1) begin
            $error("out_byte1: expected %h, got %h", want.out_byte1, got.out_byte1);
            fail_count++;
         end
         if (got.out_byte2 !== want.out_byte2) begin
            $error("out_byte2: expected %h, got %h", want.out_byte2, got.out_byte2);
            fail_count++;
         end
         if (got.out_byte3 !== want.out_byte3) begin
            $error("out_byte3: expected %h, got %h", want.out_byte3, got.out_byte3);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_took = 1'b0;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_took = 1'b1;
         check_result(rsp_tdata);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles, %0d results outstanding",
               cycle_count, pending_utf8.size());
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_char(directed_rows[i].cp, directed_rows[i].eoi, directed_rows[i].typed,
                   directed_rows[i].want);

      // random string bodies, each closed by a quote or cut short by end of input
      while (chars_sent < N_DIRECTED + RANDOM_CHARS) begin
         tx_fast = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 10)) send_piece();
         if ($urandom_range(0, 99) < 85) send_cp(jsbd_pkg::CH_QUOTE);
         else send_char(21'($urandom_range(0, 21'h1FFFFF)), 1'b1, 1'b0, '0);
         // once, let the output side empty completely before going on
         if (!paused && chars_sent >= 900) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (pending_utf8.size() != 0) @(negedge clock);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_utf8.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Sent %0d characters and checked %0d results in %0d cycles",
               chars_sent, results_seen, cycle_count);
      $display("Strings closed %0d, errors flagged %0d, early ends %0d, four-byte outputs %0d",
               done_n, error_n, eof_n, four_byte_n);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[json_string_body_decoder_core.f]
hw/rtl/jsbd_pkg.sv
hw/rtl/jsbd_front.sv
hw/rtl/jsbd_queue.sv
hw/rtl/jsbd_back.sv
hw/rtl/json_string_body_decoder_core.sv
hw/rtl/jsbd_checker.sv
verif/json_string_body_decoder_core_tb.sv
